// ===== hdl/ldnw_pkg.sv =====
// Package for the LCD decimal number writer.
// Holds payload structs, the internal job descriptor and display constants.
// No dependencies.
package ldnw_pkg;

  localparam int unsigned DIGITS    = 4;
  localparam int unsigned BIN_W     = 14;
  localparam int unsigned BCD_W     = 16;

  localparam logic [BIN_W-1:0] SAT_MAX   = 14'd9999;
  localparam logic [7:0]       ROW1_BASE = 8'h80;
  localparam logic [7:0]       ROW2_BASE = 8'hC0;
  localparam logic [7:0]       CH_SPACE  = 8'h20;
  localparam logic [3:0]       CH_DIGIT_HI = 4'h3;

  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_TWO = 2'd2;

  // Input transaction: one number to show.
  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  row;
    logic [5:0]  column;
  } num_t;

  // Output transaction: one nibble for the display bus.
  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } lcd_t;

  // Work descriptor handed from the converter to the nibble sequencer.
  typedef struct packed {
    logic [DIGITS-1:0][7:0] chars;   // chars[0] is the leftmost position
    logic                   addr_ok;
    logic [7:0]             addr;    // cursor address of the leftmost position
  } job_t;

endpackage

// ===== hdl/ldnw_front.sv =====
// Front end: accepts numbers, saturates and converts them to BCD,
// then builds the character/address job. Depends on ldnw_pkg.
module ldnw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          num_valid,
  output logic          num_ready,
  input  ldnw_pkg::num_t num,
  output logic          job_valid,
  input  logic          job_ready,
  output ldnw_pkg::job_t job
);
  import ldnw_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  localparam logic [2:0] CONV_LAST = 3'd6;  // last conversion step, 2 bits per cycle

  fstate_t          state;
  logic [2:0]       cnt;
  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [1:0]       row;
  logic [5:0]       column;

  logic             accept;
  logic [BCD_W-1:0] bcd_one;
  logic [BCD_W-1:0] bcd_two;
  logic [3:0]       dig [DIGITS];
  logic [DIGITS-1:0] blank;
  logic [7:0]       base;

  // One shift-and-add-3 step.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  assign num_ready = (state == F_IDLE) || ((state == F_PUSH) && job_ready);
  assign accept    = num_valid && num_ready;
  assign bcd_one   = dd_step(bcd, bin[BIN_W-1]);
  assign bcd_two   = dd_step(bcd_one, bin[BIN_W-2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_CONV;
            cnt   <= '0;
          end
        end
        F_CONV: begin
          cnt <= cnt + 3'd1;
          if (cnt == CONV_LAST) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (accept) begin
            state <= F_CONV;
            cnt   <= '0;
          end else if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath: load on accept, shift two bits per conversion cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      bin    <= (num.value > {2'b00, SAT_MAX}) ? SAT_MAX : num.value[BIN_W-1:0];
      bcd    <= '0;
      row    <= num.row;
      column <= num.column;
    end else if (state == F_CONV) begin
      bin <= {bin[BIN_W-3:0], 2'b00};
      bcd <= bcd_two;
    end
  end

  assign base = (row == ROW_ONE) ? ROW1_BASE : ROW2_BASE;

  // Leading-zero blanking; the units digit always prints.
  always_comb begin
    for (int p = 0; p < DIGITS; p++) begin
      dig[p] = bcd[(DIGITS-1-p)*4 +: 4];
    end
    blank[0] = (dig[0] == 4'd0);
    blank[1] = blank[0] && (dig[1] == 4'd0);
    blank[2] = blank[1] && (dig[2] == 4'd0);
    blank[3] = 1'b0;
    for (int p = 0; p < DIGITS; p++) begin
      job.chars[p] = blank[p] ? CH_SPACE : {CH_DIGIT_HI, dig[p]};
    end
    job.addr_ok = (row == ROW_ONE) || (row == ROW_TWO);
    job.addr    = base + {2'b00, column} - 8'd1;
  end

  assign job_valid = (state == F_PUSH);

endmodule

// ===== hdl/ldnw_queue.sv =====
// Two-entry job queue between converter and nibble sequencer.
// Depends on ldnw_pkg.
module ldnw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ldnw_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output ldnw_pkg::job_t rd_job
);
  import ldnw_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== hdl/ldnw_back.sv =====
// Back end: walks one job and emits its nibbles, one per cycle while lcd_ready
// is high, through a registered output stage. Depends on ldnw_pkg.
module ldnw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  ldnw_pkg::job_t job_in,
  output logic           lcd_valid,
  input  logic           lcd_ready,
  output ldnw_pkg::lcd_t lcd
);
  import ldnw_pkg::*;

  localparam logic [1:0] SUB_ADDR_HI = 2'd0;
  localparam logic [1:0] SUB_ADDR_LO = 2'd1;
  localparam logic [1:0] SUB_CHAR_HI = 2'd2;
  localparam logic [1:0] SUB_CHAR_LO = 2'd3;
  localparam logic [1:0] POS_LAST    = 2'd3;

  job_t       job;
  logic       active;
  logic [1:0] pos;
  logic [1:0] sub;
  logic       load;
  logic       is_last;
  logic [7:0] addr_cur;
  logic [7:0] ch;
  lcd_t       nib_next;

  assign load      = active && (!lcd_valid || lcd_ready);
  assign is_last   = (pos == POS_LAST) && (sub == SUB_CHAR_LO);
  assign job_ready = !active || (load && is_last);
  assign addr_cur  = job.addr + {6'b000000, pos};
  assign ch        = job.chars[pos];

  always_comb begin
    nib_next.reg_select = sub[1];
    nib_next.last       = is_last;
    unique case (sub)
      SUB_ADDR_HI: nib_next.nibble = addr_cur[7:4];
      SUB_ADDR_LO: nib_next.nibble = addr_cur[3:0];
      SUB_CHAR_HI: nib_next.nibble = ch[7:4];
      SUB_CHAR_LO: nib_next.nibble = ch[3:0];
      default:     nib_next.nibble = ch[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      lcd_valid <= 1'b0;
      pos       <= '0;
      sub       <= '0;
    end else begin
      if (load) begin
        lcd_valid <= 1'b1;
      end else if (lcd_ready) begin
        lcd_valid <= 1'b0;
      end
      if (job_valid && job_ready) begin
        active <= 1'b1;
        pos    <= '0;
        sub    <= job_in.addr_ok ? SUB_ADDR_HI : SUB_CHAR_HI;
      end else if (load) begin
        if (is_last) begin
          active <= 1'b0;
        end else if (sub == SUB_CHAR_LO) begin
          pos <= pos + 2'd1;
          sub <= job.addr_ok ? SUB_ADDR_HI : SUB_CHAR_HI;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job <= job_in;
    end
    if (load) begin
      lcd <= nib_next;
    end
  end

endmodule

// ===== hdl/lcd_decimal_number_writer_unit.sv =====
// Top level of the LCD decimal number writer.
// Instantiates ldnw_front, ldnw_queue and ldnw_back; uses ldnw_pkg.
//
//   channel | handshake            | payload          | moves
//   --------+----------------------+------------------+-----------------------------
//   number  | num_valid/num_ready  | num (num_t)      | value, row, column
//   display | lcd_valid/lcd_ready  | lcd (lcd_t)      | reg_select, nibble, last
//
// Each number produces 16 nibble transactions (row 1 or 2) or 8 (other rows),
// one per cycle while lcd_ready is high; the output sequencer sets the
// sustained rate. The front runs two binary-to-BCD steps per cycle, then
// hands the job off from its push state, and overlaps the back end
// through a two-entry job queue. Reset (synchronous, rst high) empties the
// queue and drops any transaction in flight. A stall on lcd_ready holds the
// output register and backs up into the queue and then num_ready.
module lcd_decimal_number_writer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           num_valid,
  output logic           num_ready,
  input  ldnw_pkg::num_t num,
  output logic           lcd_valid,
  input  logic           lcd_ready,
  output ldnw_pkg::lcd_t lcd
);
  import ldnw_pkg::*;

  // Converter to queue.
  logic job_valid;
  logic job_ready;
  job_t job;

  // Queue to sequencer.
  logic q_valid;
  logic q_ready;
  job_t q_job;

  // Saturate, convert to BCD, blank leading zeros, form the cursor address.
  ldnw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // Decouple the converter from the nibble stream.
  ldnw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (job_valid),
    .wr_ready (job_ready),
    .wr_job   (job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  // Emit address (rows 1 and 2 only) and character nibbles, high then low, per position.
  ldnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_in    (q_job),
    .lcd_valid (lcd_valid),
    .lcd_ready (lcd_ready),
    .lcd       (lcd)
  );

endmodule
